>>> design/stxfr_pkg.sv
// Package for the STX/ETX command framer: payload structs, the queued job
// record, protocol characters and the command digit helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stxfr_pkg;

    // protocol characters
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CSUM_MASK = 8'h7F;
    localparam logic [7:0] CSUM_SET  = 8'h40;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // byte slots of one job, in transmit order
    localparam int NUM_STEPS = 10;
    localparam logic [3:0] STEP_STX    = 4'd0;
    localparam logic [3:0] STEP_PORT   = 4'd1;
    localparam logic [3:0] STEP_COMMA1 = 4'd2;
    localparam logic [3:0] STEP_TENS   = 4'd3;
    localparam logic [3:0] STEP_ONES   = 4'd4;
    localparam logic [3:0] STEP_COMMA2 = 4'd5;
    localparam logic [3:0] STEP_ARG    = 4'd6;
    localparam logic [3:0] STEP_COMMA3 = 4'd7;
    localparam logic [3:0] STEP_CSUM   = 4'd8;
    localparam logic [3:0] STEP_ETX    = 4'd9;

    typedef struct packed {
        logic [3:0] port_digit;
        logic [6:0] command;
        logic [7:0] arg_byte;
        logic       first_item;
        logic       last_item;
        logic       has_argument;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_done;
    } out_item_t;

    // one classified item: which byte groups to send and their values
    typedef struct packed {
        logic       send_header;
        logic       send_arg;
        logic       send_comma;
        logic       send_trailer;
        logic [7:0] port_ch;
        logic [7:0] tens_ch;
        logic [7:0] ones_ch;
        logic [7:0] arg_byte;
        logic [7:0] csum;
    } job_t;

    // command reduced below 100
    function automatic logic [6:0] cmd_mod100(input logic [6:0] c);
        logic [6:0] v;
        v = (c >= 7'd100) ? (c - 7'd100) : c;
        return v;
    endfunction

    // tens digit of a value below 100, by independent threshold compares
    function automatic logic [3:0] dec_tens(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) begin
                t = 4'(k);
            end
        end
        return t;
    endfunction

    // ones digit of a value below 100, given its tens digit
    function automatic logic [3:0] dec_ones(input logic [6:0] v, input logic [3:0] t);
        logic [6:0] r;
        r = v - ({3'd0, t} * 7'd10);
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

>>> design/stx_etx_command_framer.sv
// Top level of the STX/ETX command framer: front end, job queue and byte
// sequencer. Depends on stxfr_pkg, stxfr_front, stxfr_queue, stxfr_back.
`timescale 1ns / 1ps
`default_nettype none

// Builds ASCII command frames: STX, port digit, comma, two command digits,
// comma, optional argument bytes, a comma if there was an argument, the
// checksum and ETX. Each input transfer carries one item; it yields 0 to 10
// output bytes, and frame_done marks the last byte of that item. An item is
// accepted whenever the job queue (QUEUE_DEPTH entries) has room, so a
// stream of argument bytes moves at one item per cycle. The output side
// sends one byte per cycle from its output register while result_ready is
// high; the header (6 bytes) and trailer (2 or 3 bytes) are absorbed by the
// queue while argument items keep arriving. An accepted item passes through
// a queue slot, the job register and then the output register.
module stx_etx_command_framer #(
    parameter int QUEUE_DEPTH = stxfr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire stxfr_pkg::in_item_t  item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output stxfr_pkg::out_item_t      result
);
    import stxfr_pkg::*;

    // front to queue
    logic push;
    job_t push_job;

    // queue to back
    job_t head_job;
    logic queue_full;
    logic queue_empty;
    logic pop;

    // classify each item and track the frame checksum
    stxfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // hold jobs until the sequencer is free
    stxfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // advance through the byte slots of each job, one transfer per cycle unless stalled
    stxfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> design/stxfr_front.sv
// Front end of the framer: accepts input items, keeps the frame checksum
// and argument mode, and builds one job per byte-emitting item. Uses stxfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stxfr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire stxfr_pkg::in_item_t item,
    input  wire logic               queue_full,
    output logic                    push,
    output stxfr_pkg::job_t         push_job
);
    import stxfr_pkg::*;

    logic [7:0] running_sum_reg, running_sum_next;
    logic       argument_mode_reg, argument_mode_next;

    logic       accept;
    logic [6:0] cmd_v;
    logic [3:0] port_v;
    logic [3:0] tens_d, ones_d;
    logic [7:0] tens_ch, ones_ch;
    logic [7:0] sum_base, sum_arg, csum_raw;
    logic       mode_cur, emit_arg;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        port_v   = (item.port_digit >= 4'd10) ? (item.port_digit - 4'd10) : item.port_digit;
        cmd_v    = cmd_mod100(item.command);
        tens_d   = dec_tens(cmd_v);
        ones_d   = dec_ones(cmd_v, tens_d);
        tens_ch  = CH_ZERO + {4'd0, tens_d};
        ones_ch  = CH_ZERO + {4'd0, ones_d};

        // a new frame restarts the sum from the command digits and comma
        sum_base = item.first_item ? (tens_ch + ones_ch + CH_COMMA) : running_sum_reg;
        mode_cur = item.first_item ? item.has_argument : argument_mode_reg;
        emit_arg = item.has_argument && mode_cur;
        sum_arg  = sum_base + (emit_arg ? item.arg_byte : 8'd0);
        csum_raw = 8'd0 - sum_arg;

        push_job.send_header  = item.first_item;
        push_job.send_arg     = emit_arg;
        push_job.send_comma   = item.last_item && mode_cur;
        push_job.send_trailer = item.last_item;
        push_job.port_ch      = CH_ZERO + {4'd0, port_v};
        push_job.tens_ch      = tens_ch;
        push_job.ones_ch      = ones_ch;
        push_job.arg_byte     = item.arg_byte;
        push_job.csum         = (csum_raw & CSUM_MASK) | CSUM_SET;

        // drop items that emit nothing
        push = accept && (item.first_item || emit_arg || item.last_item);

        running_sum_next   = running_sum_reg;
        argument_mode_next = argument_mode_reg;
        if (accept)
        begin
            running_sum_next   = item.last_item ? 8'd0 : sum_arg;
            argument_mode_next = item.last_item ? 1'b0 : mode_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= 8'd0;
            argument_mode_reg <= 1'b0;
        end
        else
        begin
            running_sum_reg   <= running_sum_next;
            argument_mode_reg <= argument_mode_next;
        end
    end

endmodule

`default_nettype wire

>>> design/stxfr_queue.sv
// Small job queue that decouples the framer front end from the byte
// sequencer. Uses stxfr_pkg for the job record.
`timescale 1ns / 1ps
`default_nettype none

module stxfr_queue #(
    parameter int DEPTH = stxfr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire stxfr_pkg::job_t push_job,
    input  wire logic            pop,
    output stxfr_pkg::job_t      head_job,
    output logic                 full,
    output logic                 empty
);
    import stxfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/stxfr_back.sv
// Back end of the framer: takes jobs from the queue and sends their bytes
// one per cycle through an output register unless stalled. Uses stxfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stxfr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            queue_empty,
    input  wire stxfr_pkg::job_t head_job,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output stxfr_pkg::out_item_t result
);
    import stxfr_pkg::*;

    job_t                 job_reg, job_next;
    logic [NUM_STEPS-1:0] pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 active, emit, last_byte;
    logic [3:0]           step;
    logic [NUM_STEPS-1:0] pend_left;
    logic [7:0]           cur_byte;

    assign active       = (pend_reg != '0);
    assign emit         = active && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        // lowest pending slot is the next byte to send
        step = STEP_STX;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                step = 4'(i);
            end
        end
        pend_left = pend_reg & ~(NUM_STEPS'(1) << step);
        last_byte = (pend_left == '0);

        case (step)
            STEP_STX:    cur_byte = CH_STX;
            STEP_PORT:   cur_byte = job_reg.port_ch;
            STEP_COMMA1: cur_byte = CH_COMMA;
            STEP_TENS:   cur_byte = job_reg.tens_ch;
            STEP_ONES:   cur_byte = job_reg.ones_ch;
            STEP_COMMA2: cur_byte = CH_COMMA;
            STEP_ARG:    cur_byte = job_reg.arg_byte;
            STEP_COMMA3: cur_byte = CH_COMMA;
            STEP_CSUM:   cur_byte = job_reg.csum;
            STEP_ETX:    cur_byte = CH_ETX;
            default:     cur_byte = CH_ETX;
        endcase

        // load the next job when idle or as the current one sends its last byte
        pop = !queue_empty && (!active || (emit && last_byte));

        job_next  = job_reg;
        pend_next = pend_reg;
        if (emit)
        begin
            pend_next = pend_left;
        end
        if (pop)
        begin
            job_next  = head_job;
            pend_next = {head_job.send_trailer, head_job.send_trailer,
                         head_job.send_comma, head_job.send_arg,
                         {6{head_job.send_header}}};
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.out_byte   = cur_byte;
            out_next.frame_done = last_byte;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
